[hdl/scdm_pkg.sv]
// ----------------------------------------------------------------------------
// scdm_pkg
// Shared types, constants and the sine quarter-wave table of the chorus core.
// ----------------------------------------------------------------------------
`default_nettype none

package scdm_pkg;

  localparam int SINE_TABLE_SIZE = 256;
  localparam int SINE_IW         = 8;
  localparam int SUM_W           = 28;
  localparam int WET_W           = 25;
  localparam int ACC_W           = 43;
  localparam int CFG_IW          = 3;
  localparam int CFG_DW          = 19;

  localparam logic [CFG_IW-1:0] CFG_LFO_STEP      = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_BASE_DELAY    = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_MOD_DEPTH     = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_FEEDBACK_GAIN = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_MIX_LEVEL     = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_VOICE_COUNT   = 3'd5;

  typedef struct packed {
    logic        [15:0] lfo_step;
    logic        [18:0] base_delay;
    logic        [15:0] mod_depth;
    logic signed [15:0] feedback_gain;
    logic        [15:0] mix_level;
    logic        [2:0]  voice_count;
  } cfg_t;

  typedef struct packed {
    logic clr;
    logic accept;
    logic fb;
    logic wr;
    logic lfo;
    logic ofs;
    logic pos;
    logic rda;
    logic rdb;
    logic accb;
    logic div;
    logic mix1;
    logic mix2;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic last_voice;
  } sts_t;

  typedef logic [14:0] sine_rom_t [SINE_TABLE_SIZE];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    for (int k = 0; k < SINE_TABLE_SIZE; k++) begin
      x  = (64'd1686629713 * (64'(2 * k) + 64'd1)) >> (SINE_IW + 1);
      x2 = (x * x) >> 30;
      t  = ((x * x2) >> 30) / 64'd6;
      s  = x - t;
      t  = ((t * x2) >> 30) / 64'd20;
      s  = s + t;
      t  = ((t * x2) >> 30) / 64'd42;
      s  = s - t;
      t  = ((t * x2) >> 30) / 64'd72;
      s  = s + t;
      t  = ((t * x2) >> 30) / 64'd110;
      s  = s - t;
      s  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      rom[k] = s[14:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // floor(2^30 / v) + 1, exact quotient for magnitudes below 2^27
  function automatic logic [30:0] recip(input logic [3:0] v);
    logic [30:0] r;
    case (v)
      4'd2:    r = 31'd536870913;
      4'd3:    r = 31'd357913942;
      4'd4:    r = 31'd268435457;
      4'd5:    r = 31'd214748365;
      4'd6:    r = 31'd178956971;
      4'd7:    r = 31'd153391690;
      4'd8:    r = 31'd134217729;
      default: r = 31'd1073741825;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    logic signed [15:0] r;
    if (v > 24'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/scdm_ctrl.sv]
// ----------------------------------------------------------------------------
// scdm_ctrl
// Sequencer of the chorus core: clearing pass, per-frame steps, output hold.
// ----------------------------------------------------------------------------
`default_nettype none

module scdm_ctrl
  import scdm_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire  out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [13:0] {
    ST_CLEAR = 14'h0001,
    ST_IDLE  = 14'h0002,
    ST_FB    = 14'h0004,
    ST_WR    = 14'h0008,
    ST_LFO   = 14'h0010,
    ST_OFS   = 14'h0020,
    ST_POS   = 14'h0040,
    ST_RDA   = 14'h0080,
    ST_RDB   = 14'h0100,
    ST_ACCB  = 14'h0200,
    ST_DIV   = 14'h0400,
    ST_MIX1  = 14'h0800,
    ST_MIX2  = 14'h1000,
    ST_DONE  = 14'h2000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = ST_FB;
      end
      ST_FB: begin
        cmd_o.fb = 1'b1;
        state_d  = ST_WR;
      end
      ST_WR: begin
        cmd_o.wr = 1'b1;
        state_d  = ST_LFO;
      end
      ST_LFO: begin
        cmd_o.lfo = 1'b1;
        state_d   = ST_OFS;
      end
      ST_OFS: begin
        cmd_o.ofs = 1'b1;
        state_d   = ST_POS;
      end
      ST_POS: begin
        cmd_o.pos = 1'b1;
        state_d   = ST_RDA;
      end
      ST_RDA: begin
        cmd_o.rda = 1'b1;
        state_d   = ST_RDB;
      end
      ST_RDB: begin
        cmd_o.rdb = 1'b1;
        state_d   = ST_ACCB;
      end
      ST_ACCB: begin
        cmd_o.accb = 1'b1;
        state_d    = sts_i.last_voice ? ST_DIV : ST_LFO;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_MIX1;
      end
      ST_MIX1: begin
        cmd_o.mix1 = 1'b1;
        state_d    = ST_MIX2;
      end
      ST_MIX2: begin
        cmd_o.mix2 = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        cmd_o.load_out = out_free;
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (state_q == ST_IDLE && out_valid_q))
    else $error("finished frame not loaded into output");
  a_rise_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("output valid without a finished frame");
  a_last_voice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACCB && sts_i.last_voice) |=> state_q == ST_DIV)
    else $error("voice loop did not end on last voice");
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i) |=> state_q == ST_FB)
    else $error("accepted frame not started");
`endif

endmodule

`default_nettype wire

[hdl/scdm_datapath.sv]
// ----------------------------------------------------------------------------
// scdm_datapath
// Delay lines, LFO phases, tap interpolation, voice averaging and mixing.
// ----------------------------------------------------------------------------
`default_nettype none

module scdm_datapath
  import scdm_pkg::*;
#(
  parameter int DELAY_DEPTH     = 2048,
  parameter int MAX_VOICE_COUNT = 4
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  cfg_t        cfg_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  wire  [31:0] in_data_i,
  output logic [31:0] out_data_o
);

  localparam int AW  = $clog2(DELAY_DEPTH);
  localparam int PW  = AW + 8;
  localparam int DW  = (PW + 2 > 22) ? PW + 2 : 22;
  localparam int VIW = (MAX_VOICE_COUNT > 1) ? $clog2(MAX_VOICE_COUNT) : 1;
  localparam logic [AW-1:0]        LAST_ADDR = AW'(DELAY_DEPTH - 1);
  localparam logic signed [DW-1:0] D_LO      = DW'(256);
  localparam logic signed [DW-1:0] D_HI      = DW'((DELAY_DEPTH - 1) * 256);
  localparam logic signed [PW+1:0] POS_WRAP  = (PW + 2)'(DELAY_DEPTH * 256);

  logic signed [15:0] mem_l [DELAY_DEPTH];
  logic signed [15:0] mem_r [DELAY_DEPTH];
  logic signed [15:0] rdl_q, rdr_q;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               we;
  logic signed [15:0] wdl, wdr;

  logic [AW-1:0]      wp_q, clr_cnt_q, prev_addr, i0, i1;
  logic signed [15:0] inl_q, inr_q;
  logic signed [31:0] fbl_q, fbr_q;
  logic [18:0]        span_q;
  logic signed [15:0] lfo_q;
  logic signed [20:0] ofs_q;
  logic [PW-1:0]      pos_q;
  logic signed [SUM_W-1:0] suml_q, sumr_q;
  logic [VIW-1:0]     vcnt_q;
  logic [23:0]        phase_q [MAX_VOICE_COUNT];
  logic signed [WET_W-1:0] wetl_q, wetr_q;
  logic signed [ACC_W-1:0] accl_q, accr_q;
  logic signed [15:0] outl_q, outr_q;

  logic [15:0]        depthc, mixc, dry;
  logic signed [15:0] fbc;
  logic [3:0]         voices;
  logic [23:0]        phase;
  logic [SINE_IW-1:0] sidx;
  logic [14:0]        smag;
  logic signed [35:0] ofs_prod;
  logic signed [DW-1:0] d_s;
  logic [PW-1:0]      dc;
  logic signed [PW+1:0] posd;
  logic [7:0]         frac;
  logic signed [9:0]  wa, wb;
  logic [26:0]        magl, magr;
  logic [57:0]        ql_prod, qr_prod;
  logic [26:0]        ql, qr;

  assign depthc = (cfg_i.mod_depth > 16'd32768) ? 16'd32768 : cfg_i.mod_depth;
  assign mixc   = (cfg_i.mix_level > 16'd32768) ? 16'd32768 : cfg_i.mix_level;
  assign dry    = 16'd32768 - mixc;
  assign fbc    = (cfg_i.feedback_gain > 16'sd16384) ? 16'sd16384 :
                  (cfg_i.feedback_gain < -16'sd16384) ? -16'sd16384 : cfg_i.feedback_gain;
  assign voices = (cfg_i.voice_count == 3'd0) ? 4'd1 :
                  ({1'b0, cfg_i.voice_count} > 4'(MAX_VOICE_COUNT)) ?
                  4'(MAX_VOICE_COUNT) : {1'b0, cfg_i.voice_count};

  assign sts_o.clr_done   = (clr_cnt_q == LAST_ADDR);
  assign sts_o.last_voice = (4'(vcnt_q) == voices - 4'd1);

  assign prev_addr = (wp_q == '0) ? LAST_ADDR : wp_q - AW'(1);
  assign i0        = pos_q[PW-1:8];
  assign i1        = (i0 == LAST_ADDR) ? '0 : i0 + AW'(1);
  assign frac      = pos_q[7:0];
  assign wb        = $signed({2'b00, frac});
  assign wa        = 10'sd256 - wb;

  assign rd_addr = cmd_i.accept ? prev_addr : (cmd_i.rda ? i0 : i1);
  assign we      = cmd_i.clr || cmd_i.wr;
  assign wr_addr = cmd_i.clr ? clr_cnt_q : wp_q;
  assign wdl     = cmd_i.clr ? '0 : sat16(24'(inl_q) + 24'(fbl_q >>> 15));
  assign wdr     = cmd_i.clr ? '0 : sat16(24'(inr_q) + 24'(fbr_q >>> 15));

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_l[wr_addr] <= wdl;
      mem_r[wr_addr] <= wdr;
    end
    rdl_q <= mem_l[rd_addr];
    rdr_q <= mem_r[rd_addr];
  end

  assign phase = phase_q[vcnt_q];
  assign sidx  = phase[22] ? ~phase[21:22-SINE_IW] : phase[21:22-SINE_IW];
  assign smag  = SINE_ROM[sidx];

  assign ofs_prod = lfo_q * $signed({1'b0, span_q});
  assign d_s      = $signed({(DW-19)'(0), cfg_i.base_delay}) + DW'(ofs_q);
  assign dc       = (d_s < D_LO) ? PW'(D_LO) : (d_s > D_HI) ? PW'(D_HI) : d_s[PW-1:0];
  assign posd     = $signed({2'b00, wp_q, 8'd0}) - $signed({2'b00, dc});

  assign magl    = suml_q[SUM_W-1] ? 27'(-suml_q) : 27'(suml_q);
  assign magr    = sumr_q[SUM_W-1] ? 27'(-sumr_q) : 27'(sumr_q);
  assign ql_prod = 58'(magl) * 58'(recip(voices));
  assign qr_prod = 58'(magr) * 58'(recip(voices));
  assign ql      = ql_prod[56:30];
  assign qr      = qr_prod[56:30];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      inl_q <= in_data_i[15:0];
      inr_q <= in_data_i[31:16];
    end
    if (cmd_i.fb) begin
      fbl_q  <= rdl_q * fbc;
      fbr_q  <= rdr_q * fbc;
      span_q <= 19'((35'(cfg_i.base_delay) * 35'(depthc)) >> 15);
    end
    if (cmd_i.lfo) begin
      lfo_q <= phase[23] ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
    end
    if (cmd_i.ofs) ofs_q <= ofs_prod[35:15];
    if (cmd_i.pos) pos_q <= (posd < 0) ? PW'(posd + POS_WRAP) : PW'(posd);
    if (cmd_i.wr) begin
      suml_q <= '0;
      sumr_q <= '0;
    end else if (cmd_i.rdb) begin
      suml_q <= suml_q + SUM_W'(rdl_q) * SUM_W'(wa);
      sumr_q <= sumr_q + SUM_W'(rdr_q) * SUM_W'(wa);
    end else if (cmd_i.accb) begin
      suml_q <= suml_q + SUM_W'(rdl_q) * SUM_W'(wb);
      sumr_q <= sumr_q + SUM_W'(rdr_q) * SUM_W'(wb);
    end
    if (cmd_i.div) begin
      wetl_q <= suml_q[SUM_W-1] ? -WET_W'(ql) : WET_W'(ql);
      wetr_q <= sumr_q[SUM_W-1] ? -WET_W'(qr) : WET_W'(qr);
    end
    if (cmd_i.mix1) begin
      accl_q <= (ACC_W'(inl_q) * ACC_W'($signed({1'b0, dry}))) <<< 8;
      accr_q <= (ACC_W'(inr_q) * ACC_W'($signed({1'b0, dry}))) <<< 8;
    end else if (cmd_i.mix2) begin
      accl_q <= accl_q + ACC_W'(wetl_q) * ACC_W'($signed({1'b0, mixc})) + ACC_W'(1 << 22);
      accr_q <= accr_q + ACC_W'(wetr_q) * ACC_W'($signed({1'b0, mixc})) + ACC_W'(1 << 22);
    end
    if (cmd_i.load_out) begin
      outl_q <= sat16(24'(accl_q >>> 23));
      outr_q <= sat16(24'(accr_q >>> 23));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      clr_cnt_q <= '0;
      vcnt_q    <= '0;
      for (int v = 0; v < MAX_VOICE_COUNT; v++) begin
        phase_q[v] <= 24'((64'(v) << 24) / MAX_VOICE_COUNT);
      end
    end else begin
      if (cmd_i.clr) clr_cnt_q <= clr_cnt_q + AW'(1);
      if (cmd_i.load_out) wp_q <= (wp_q == LAST_ADDR) ? '0 : wp_q + AW'(1);
      if (cmd_i.accept) begin
        vcnt_q <= '0;
      end else if (cmd_i.accb) begin
        phase_q[vcnt_q] <= phase + 24'(cfg_i.lfo_step);
        vcnt_q          <= vcnt_q + VIW'(1);
      end
    end
  end

  assign out_data_o = {outr_q, outl_q};

endmodule

`default_nettype wire

[hdl/stereo_chorus_delay_modulator_core.sv]
// ----------------------------------------------------------------------------
// stereo_chorus_delay_modulator_core
// Stereo multi-voice chorus with feedback delay lines and sine LFO modulation.
// ----------------------------------------------------------------------------
// channel   | direction | handshake            | payload
// s_axis    | in        | tvalid / tready      | tdata: in_left, in_right
// m_axis    | out       | tvalid / tready      | tdata: out_left, out_right
// cfg       | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Frames are processed one at a time by a serial voice loop sharing one read
// port per delay line; no new frame is taken before the last one is finished.
// After reset every entry of the delay lines is cleared; no frame is taken
// meanwhile. A result waiting in the output register does not block the
// next frame until that frame is finished.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_chorus_delay_modulator_core
  import scdm_pkg::*;
#(
  parameter int DELAY_DEPTH     = 2048,
  parameter int MAX_VOICE_COUNT = 4
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire  [31:0]       s_axis_tdata,   // in_left [15:0], in_right [31:16]
  output logic              m_axis_tvalid,
  input  wire               m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // out_left [15:0], out_right [31:16]
  input  wire               cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire  [CFG_IW-1:0] cfg_index_i,
  input  wire  [CFG_DW-1:0] cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LFO_STEP:      cfg_d.lfo_step      = cfg_data_i[15:0];
        CFG_BASE_DELAY:    cfg_d.base_delay    = cfg_data_i[18:0];
        CFG_MOD_DEPTH:     cfg_d.mod_depth     = cfg_data_i[15:0];
        CFG_FEEDBACK_GAIN: cfg_d.feedback_gain = cfg_data_i[15:0];
        CFG_MIX_LEVEL:     cfg_d.mix_level     = cfg_data_i[15:0];
        CFG_VOICE_COUNT:   cfg_d.voice_count   = cfg_data_i[2:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lfo_step      <= 16'd1398;
      cfg_q.base_delay    <= 19'd73728;
      cfg_q.mod_depth     <= 16'd16384;
      cfg_q.feedback_gain <= 16'sd0;
      cfg_q.mix_level     <= 16'd16384;
      cfg_q.voice_count   <= 3'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  scdm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  scdm_datapath #(
    .DELAY_DEPTH     (DELAY_DEPTH),
    .MAX_VOICE_COUNT (MAX_VOICE_COUNT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression of the stereo chorus core. Frames are streamed in
// under several register settings, in bursts or with random gaps on both
// sides. A bit-exact predictor of the chorus produces the expected output
// frames, which are compared in order with what the core delivers.
// ----------------------------------------------------------------------------

module testbench;
  import scdm_pkg::*;

  localparam int DEPTH       = 2048;
  localparam int VOICES_MAX  = 4;
  localparam int IDLE_LIMIT  = 20000;
  localparam int DRAIN_WAIT  = 6 + 6 * VOICES_MAX + 12;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 250;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } frame_t;

  typedef struct packed {
    frame_t in;
    logic   known;
    frame_t out;
  } stim_t;

  // directed frames under reset settings; delay lines still hold zeros here
  localparam int DIR_N = 14;
  localparam stim_t DIRECTED [DIR_N] = '{
    '{'{16'sh7FFF, 16'sh8000}, 1'b1, '{16'sd16384, -16'sd16384}},
    '{'{16'sh8000, 16'sh7FFF}, 1'b1, '{-16'sd16384, 16'sd16384}},
    '{'{16'sh0000, 16'shFFFF}, 1'b1, '{16'sd0, 16'sd0}},
    '{'{16'sh0001, 16'shFFFE}, 1'b1, '{16'sd1, -16'sd1}},
    '{'{16'sh4000, 16'shC000}, 1'b1, '{16'sd8192, -16'sd8192}},
    '{'{16'sh5555, 16'shAAAA}, 1'b0, '0},
    '{'{16'shAAAA, 16'sh5555}, 1'b0, '0},
    '{'{16'sh7FFF, 16'sh7FFF}, 1'b0, '0},
    '{'{16'sh8000, 16'sh8000}, 1'b0, '0},
    '{'{16'sh00FF, 16'shFF00}, 1'b0, '0},
    '{'{16'sh1234, 16'shEDCB}, 1'b0, '0},
    '{'{16'sh7FFE, 16'sh8001}, 1'b0, '0},
    '{'{16'sh0F0F, 16'shF0F0}, 1'b0, '0},
    '{'{16'sh0000, 16'sh0000}, 1'b0, '0}
  };

  localparam int SET_N = 7;
  // lfo_step, base_delay, mod_depth, feedback_gain, mix_level, voice_count
  logic [CFG_DW-1:0] settings [SET_N][6] = '{
    '{19'd65535, 19'd256,    19'd32768, 19'h04000, 19'd32768, 19'd4},
    '{19'd0,     19'd524032, 19'd0,     19'h0C000, 19'd0,     19'd1},
    '{19'd5000,  19'd524287, 19'd65535, 19'h07FFF, 19'd65535, 19'd0},
    '{19'd12345, 19'd2000,   19'd20000, 19'h08000, 19'd30000, 19'd7},
    '{19'd1398,  19'd100,    19'd32768, 19'd8000,  19'd16384, 19'd3},
    '{19'd700,   19'd30000,  19'd24000, 19'h0E000, 19'd20000, 19'd2},
    '{19'd0,     19'd0,      19'd0,     19'd0,     19'd0,     19'd0}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [31:0]       m_axis_tdata;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CFG_IW-1:0] cfg_index_i;
  logic [CFG_DW-1:0] cfg_data_i;

  stereo_chorus_delay_modulator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // predictor state
  logic        [15:0] p_step;
  logic        [18:0] p_base;
  logic        [15:0] p_depth;
  logic signed [15:0] p_fb;
  logic        [15:0] p_mix;
  logic        [2:0]  p_voices;
  logic signed [15:0] line_l [DEPTH];
  logic signed [15:0] line_r [DEPTH];
  int unsigned        wr_pos;
  logic        [23:0] phase [VOICES_MAX];
  int                 sine_q [256];

  frame_t expected_frames [$];
  stim_t  offered_frames [$];
  int     failures;
  int     idle_cycles;
  bit     burst;
  bit     hold_req;

  function automatic int sine_entry(input int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    x  = (64'd1686629713 * (2 * k + 1)) / 512;
    x2 = (x * x) >> 30;
    t  = x;
    s  = x;
    for (int n = 1; n <= 5; n++) begin
      t = ((t * x2) >> 30) / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) s = s - t;
      else s = s + t;
    end
    return int'((s * 32767 + (64'd1 << 29)) >> 30);
  endfunction

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint lfo_of(input logic [23:0] ph);
    int idx;
    idx = ph[21:14];
    if (ph[22]) idx = 255 - idx;
    return ph[23] ? -sine_q[idx] : sine_q[idx];
  endfunction

  function automatic longint interp_tap(input bit right, input longint d);
    longint      pos;
    int unsigned i0;
    int unsigned i1;
    longint      f;
    longint      a;
    longint      b;
    pos = longint'(wr_pos) * 256 - d;
    if (pos < 0) pos += DEPTH * 256;
    i0 = (pos >> 8) % DEPTH;
    i1 = (i0 + 1) % DEPTH;
    f  = pos & 255;
    a  = right ? line_r[i0] : line_l[i0];
    b  = right ? line_r[i1] : line_l[i1];
    return a * (256 - f) + b * f;
  endfunction

  function automatic frame_t chorus_frame(input frame_t in);
    longint      fb;
    longint      depth;
    longint      mix;
    longint      span;
    longint      d;
    longint      sum_l;
    longint      sum_r;
    longint      wet_l;
    longint      wet_r;
    int unsigned voices;
    int unsigned prev;
    frame_t      o;
    fb     = p_fb;
    depth  = (p_depth > 32768) ? 32768 : p_depth;
    mix    = (p_mix > 32768) ? 32768 : p_mix;
    voices = p_voices;
    if (fb > 16384) fb = 16384;
    if (fb < -16384) fb = -16384;
    if (voices < 1) voices = 1;
    if (voices > VOICES_MAX) voices = VOICES_MAX;
    prev = (wr_pos + DEPTH - 1) % DEPTH;
    line_l[wr_pos] = clip16(longint'(in.left) + ((longint'(line_l[prev]) * fb) >>> 15));
    line_r[wr_pos] = clip16(longint'(in.right) + ((longint'(line_r[prev]) * fb) >>> 15));
    span  = (longint'(p_base) * depth) >>> 15;
    sum_l = 0;
    sum_r = 0;
    for (int v = 0; v < voices; v++) begin
      d = longint'(p_base) + ((lfo_of(phase[v]) * span) >>> 15);
      if (d < 256) d = 256;
      if (d > (DEPTH - 1) * 256) d = (DEPTH - 1) * 256;
      sum_l += interp_tap(1'b0, d);
      sum_r += interp_tap(1'b1, d);
      phase[v] = phase[v] + p_step;
    end
    wet_l  = sum_l / longint'(voices);
    wet_r  = sum_r / longint'(voices);
    o.left  = clip16((longint'(in.left) * 256 * (32768 - mix) + wet_l * mix
                     + (longint'(1) << 22)) >>> 23);
    o.right = clip16((longint'(in.right) * 256 * (32768 - mix) + wet_r * mix
                     + (longint'(1) << 22)) >>> 23);
    wr_pos = (wr_pos + 1) % DEPTH;
    return o;
  endfunction

  initial begin
    for (int k = 0; k < 256; k++) sine_q[k] = sine_entry(k);
    for (int i = 0; i < DEPTH; i++) begin
      line_l[i] = '0;
      line_r[i] = '0;
    end
    for (int v = 0; v < VOICES_MAX; v++) phase[v] = 24'(v * (1 << 22));
    wr_pos   = 0;
    p_step   = 16'd1398;
    p_base   = 19'd73728;
    p_depth  = 16'd16384;
    p_fb     = '0;
    p_mix    = 16'd16384;
    p_voices = 3'd2;
  end

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // track transactions on all three channels
  always @(posedge clk_i) begin
    stim_t  st;
    frame_t pred;
    frame_t got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_LFO_STEP:      p_step   = cfg_data_i[15:0];
          CFG_BASE_DELAY:    p_base   = cfg_data_i[18:0];
          CFG_MOD_DEPTH:     p_depth  = cfg_data_i[15:0];
          CFG_FEEDBACK_GAIN: p_fb     = cfg_data_i[15:0];
          CFG_MIX_LEVEL:     p_mix    = cfg_data_i[15:0];
          CFG_VOICE_COUNT:   p_voices = cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        st   = offered_frames.pop_front();
        pred = chorus_frame(st.in);
        expected_frames.push_back(st.known ? st.out : pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[15:0], m_axis_tdata[31:16]};
        if (expected_frames.size() == 0) begin
          $error("unexpected output frame %h", m_axis_tdata);
          failures++;
        end else begin
          pred = expected_frames.pop_front();
          if (got.left !== pred.left) begin
            $error("out_left expected %0d actual %0d", pred.left, got.left);
            failures++;
          end
          if (got.right !== pred.right) begin
            $error("out_right expected %0d actual %0d", pred.right, got.right);
            failures++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("stereo_chorus_delay_modulator_core regression: fail");
      $finish;
    end
  end

  // output side: random stall before each transaction outside bursts, long hold on request
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = burst ? 0 : $urandom_range(17, 0);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  task automatic send_frame(input stim_t st);
    int gap;
    gap = burst ? 0 : $urandom_range(17, 0);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    offered_frames.push_back(st);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {st.in.right, st.in.left};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_frames.size() != 0 || offered_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_sample(input int style);
    logic [15:0] pick [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
    case (style)
      0:       return pick[$urandom_range(3, 0)];
      1:       return 16'($signed($urandom_range(512, 0)) - 256);
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    stim_t st;
    int    sel;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    failures      = 0;
    idle_cycles   = 0;
    burst         = 1'b0;
    hold_req      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_N; i++) send_frame(DIRECTED[i]);
    drain();

    settings[5][5] = 19'($urandom_range(4, 1));
    for (int r = 0; r < 6; r++) settings[6][r] = 19'($urandom());
    for (int p = 0; p < SET_N; p++) begin
      for (int r = 0; r < 6; r++) write_reg(CFG_IW'(r), settings[p][r]);
      cfg_valid_i <= 1'b0;
      burst    = (p == 0 || p == 4);
      hold_req = (p == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) burst = !burst;
        sel          = $urandom_range(9, 0);
        st.in.left   = rand_sample(sel < 2 ? 0 : (sel < 4 ? 1 : 2));
        st.in.right  = rand_sample(sel < 2 ? 0 : (sel < 4 ? 1 : 2));
        st.known     = 1'b0;
        st.out       = '0;
        send_frame(st);
      end
      drain();
    end

    if (failures == 0) begin
      $display("stereo_chorus_delay_modulator_core regression: pass");
    end else begin
      $display("stereo_chorus_delay_modulator_core regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/scdm_pkg.sv
hdl/scdm_ctrl.sv
hdl/scdm_datapath.sv
hdl/stereo_chorus_delay_modulator_core.sv
dv/testbench.sv
